@@ rtl/ichtm_pkg.sv @@
// Shared types and constants for the instruction-cache hit timing model.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package ichtm_pkg;

    // Geometry defaults, handed to the top-level parameters.
    localparam int DEF_NUM_WAYS = 4;
    localparam int DEF_NUM_SETS = 256;

    // Address layout: tag in bits 31:12, set index from bit 4 upward.
    localparam int ADDR_W  = 32;
    localparam int TAG_W   = 20;
    localparam int TAG_LSB = 12;
    localparam int SET_LSB = 4;

    // Cacheable window is [CACHE_LOW, CACHE_HIGH).
    localparam logic [ADDR_W-1:0] CACHE_LOW  = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] CACHE_HIGH = 32'hC000_0000;

    // Replacement LFSR.
    localparam int              LFSR_W     = 4;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 4'hC;
    localparam logic [LFSR_W-1:0] LFSR_RESET = 4'hF;

    // Configuration registers.
    localparam int DELAY_W     = 8;
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_HIT_DELAY  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MISS_DELAY = 8'd1;
    localparam logic [DELAY_W-1:0]     HIT_DELAY_RESET  = 8'd1;
    localparam logic [DELAY_W-1:0]     MISS_DELAY_RESET = 8'd10;

    typedef logic [TAG_W-1:0] tag_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

endpackage

@@ rtl/icache_hit_timing_model.sv @@
// Top level of the instruction-cache hit timing model.
// Depends on ichtm_pkg, ichtm_tag_ram and ichtm_replace.
`timescale 1ns / 1ps
//
// Usage:
// A fetch address word enters on in_valid/in_stall and is accepted at a rising
// edge where in_valid is high and in_stall is low. Each word produces exactly
// one result word (delay, hit, uncacheable) on out_valid/out_stall, taken at an
// edge where out_valid is high and out_stall is low.
// At the accept edge the set row is read from the tag memory; at the edge where
// the lookup completes, the tags of all ways are compared, the row is written back
// with the new tag on a miss, and the result is loaded into the output register.
// The input stalls while a lookup is in progress, so a new word is accepted only
// after the previous lookup has finished.
// The output register lets the next word be accepted while a result waits.
// If the receiver stalls and the output register is still full when a lookup
// completes, the lookup holds (with the row already read) until the register
// frees; no result is lost or repeated.
// Reset clears the per-row valid bits at once, so every set reads as all-zero
// tags, the LFSR returns to 0xF and the delays return to 1 and 10. No clearing
// pass is needed. Configuration writes (cfg_valid/cfg_ready) are always taken;
// indexes other than 0 and 1 are ignored.

module icache_hit_timing_model
    import ichtm_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    parameter int NUM_SETS = DEF_NUM_SETS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Fetch address channel.
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [ADDR_W-1:0]      fetch_address,
    // Result channel.
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DELAY_W-1:0]     delay,
    output logic                   hit,
    output logic                   uncacheable,
    // Configuration write channel.
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [DELAY_W-1:0]     cfg_data
);

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int WAY_W = $clog2(NUM_WAYS);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // The word being looked up.
    tag_t              tag_reg;
    logic [SET_W-1:0]  set_reg;
    logic              uncacheable_reg;

    // Configuration registers.
    logic [DELAY_W-1:0] hit_delay_reg;
    logic [DELAY_W-1:0] miss_delay_reg;

    // Output register.
    logic               out_valid_reg;
    logic [DELAY_W-1:0] delay_reg;
    logic               hit_reg;
    logic               out_uncacheable_reg;

    logic                in_fire;
    logic                out_free;
    logic                lookup_done;
    logic                hit_now;
    logic                uncacheable_now;
    logic                tag_wr_en;
    logic [WAY_W-1:0]    victim_way;
    tag_t [NUM_WAYS-1:0] rd_row;
    tag_t [NUM_WAYS-1:0] wr_row;

    // ------------------------------------------------------------------
    // Control: accept in IDLE, finish the lookup once the output is free.
    // ------------------------------------------------------------------
    assign in_fire     = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign lookup_done = (state_reg == ST_LOOKUP) && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Capture the fields of the accepted word. The cacheable window check
    // is done here so the lookup cycle only has the tag compare.
    assign uncacheable_now = !((fetch_address >= CACHE_LOW) && (fetch_address < CACHE_HIGH));

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            tag_reg         <= fetch_address[TAG_LSB +: TAG_W];
            set_reg         <= fetch_address[SET_LSB +: SET_W];
            uncacheable_reg <= uncacheable_now;
        end
    end

    // ------------------------------------------------------------------
    // Tag memory and replacement.
    // ------------------------------------------------------------------
    ichtm_tag_ram #(
        .NUM_WAYS (NUM_WAYS),
        .NUM_SETS (NUM_SETS)
    ) u_tag_ram (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (in_fire),
        .rd_set (fetch_address[SET_LSB +: SET_W]),
        .rd_row (rd_row),
        .wr_en  (tag_wr_en),
        .wr_set (set_reg),
        .wr_row (wr_row)
    );

    ichtm_replace #(
        .NUM_WAYS (NUM_WAYS)
    ) u_replace (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (tag_wr_en),
        .victim_way (victim_way)
    );

    // Compare all ways; any match is a hit, regardless of cacheability.
    always_comb
    begin
        hit_now = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (rd_row[w] == tag_reg)
            begin
                hit_now = 1'b1;
            end
        end
    end

    // On a miss the whole row is written back with the victim way replaced,
    // which also marks the row valid with its other tags intact.
    always_comb
    begin
        wr_row             = rd_row;
        wr_row[victim_way] = tag_reg;
    end

    assign tag_wr_en = lookup_done && !hit_now;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_delay_reg  <= HIT_DELAY_RESET;
            miss_delay_reg <= MISS_DELAY_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_HIT_DELAY)
            begin
                hit_delay_reg <= cfg_data;
            end
            else if (cfg_index == REG_MISS_DELAY)
            begin
                miss_delay_reg <= cfg_data;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (lookup_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lookup_done)
        begin
            delay_reg           <= (hit_now && !uncacheable_reg) ? hit_delay_reg
                                                                 : miss_delay_reg;
            hit_reg             <= hit_now;
            out_uncacheable_reg <= uncacheable_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign delay       = delay_reg;
    assign hit         = hit_reg;
    assign uncacheable = out_uncacheable_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_accept_starts_lookup: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_LOOKUP)
    ) else $error("accepted word did not start a lookup");

    a_write_only_when_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        tag_wr_en |-> (state_reg == ST_LOOKUP) && out_free
    ) else $error("tag write outside a completing lookup");

    a_blocked_lookup_holds: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOOKUP) && !out_free
            |=> (state_reg == ST_LOOKUP) && $stable(set_reg) && $stable(tag_reg)
    ) else $error("blocked lookup lost its word");

    a_done_fills_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        lookup_done |=> out_valid_reg
    ) else $error("completed lookup did not load the output register");

endmodule

@@ rtl/ichtm_tag_ram.sv @@
// Tag store: one row per set holding all ways, synchronous read, one write port.
// Depends on ichtm_pkg. A per-row valid bit makes unwritten rows read as zero tags.
`timescale 1ns / 1ps

module ichtm_tag_ram
    import ichtm_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    parameter int NUM_SETS = DEF_NUM_SETS,
    localparam int SET_W   = $clog2(NUM_SETS)
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         rd_en,
    input  logic [SET_W-1:0]             rd_set,
    output tag_t [NUM_WAYS-1:0]          rd_row,
    input  logic                         wr_en,
    input  logic [SET_W-1:0]             wr_set,
    input  tag_t [NUM_WAYS-1:0]          wr_row
);

    tag_t [NUM_WAYS-1:0] mem [NUM_SETS];
    tag_t [NUM_WAYS-1:0] rd_data_reg;
    logic [NUM_SETS-1:0] row_valid_reg;
    logic                rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_set] <= wr_row;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_set];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                row_valid_reg[wr_set] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_set];
            end
        end
    end

    // A row never written since reset reads as all tags zero.
    assign rd_row = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/ichtm_replace.sv @@
// Way-replacement LFSR: a 4-bit Galois LFSR that steps once per miss.
// Depends on ichtm_pkg. The victim way comes from the stepped value.
`timescale 1ns / 1ps

module ichtm_replace
    import ichtm_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS,
    localparam int WAY_W   = $clog2(NUM_WAYS)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    output logic [WAY_W-1:0] victim_way
);

    logic [LFSR_W-1:0] lfsr_reg;
    logic [LFSR_W-1:0] lfsr_next;

    always_comb
    begin
        if (lfsr_reg[0])
        begin
            lfsr_next = (lfsr_reg >> 1) ^ LFSR_TAPS;
        end
        else
        begin
            lfsr_next = lfsr_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_reg <= LFSR_RESET;
        end
        else if (advance)
        begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign victim_way = lfsr_next[WAY_W-1:0];

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for icache_hit_timing_model: directed and random fetch words,
// delay reprogramming and a tag-store/LFSR predictor. Depends on ichtm_pkg and the block RTL.

module tb_top;
    import ichtm_pkg::*;

    localparam int WAYS = DEF_NUM_WAYS;
    localparam int SETS = DEF_NUM_SETS;
    localparam int SET_W = $clog2(SETS);
    localparam int WAY_W = $clog2(WAYS);
    localparam int CLK_HALF = 5;
    localparam int IDLE_MAX = 17;
    // Settling time after the last result, covering the lookup and the output register.
    localparam int DRAIN_CYCLES = 8;
    // Longest quiet stretch of a correct run is a sender gap plus a receiver stall plus
    // the pipeline; the limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES = 8;
    localparam int WORDS_PER_PHASE = 210;
    localparam int POOL_SIZE = 8;
    localparam logic [DELAY_W-1:0] DELAY_MAX = '1;

    // One result word as the block reports it.
    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic               hit;
        logic               uncacheable;
    } fetch_timing_t;

    // Predicts the timing of every accepted fetch and checks result words in order.
    class fetch_timing_predictor;
        tag_t               tags [WAYS][SETS];
        logic [LFSR_W-1:0]  lfsr;
        logic [DELAY_W-1:0] hit_delay;
        logic [DELAY_W-1:0] miss_delay;
        fetch_timing_t      pending_timings [$];
        int                 mismatches;

        function new();
            foreach (tags[w, s])
                tags[w][s] = '0;
            lfsr = LFSR_RESET;
            hit_delay = HIT_DELAY_RESET;
            miss_delay = MISS_DELAY_RESET;
            mismatches = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [DELAY_W-1:0] data);
            if (index == REG_HIT_DELAY)
                hit_delay = data;
            else if (index == REG_MISS_DELAY)
                miss_delay = data;
        endfunction

        function void note_fetch(logic [ADDR_W-1:0] addr);
            tag_t             tag;
            logic [SET_W-1:0] set_idx;
            fetch_timing_t    t;
            tag = addr[ADDR_W-1 -: TAG_W];
            set_idx = addr[SET_LSB +: SET_W];
            t.uncacheable = !((addr >= CACHE_LOW) && (addr < CACHE_HIGH));
            t.hit = 1'b0;
            for (int w = 0; w < WAYS; w++)
                if (tags[w][set_idx] == tag)
                    t.hit = 1'b1;
            if (!t.hit)
            begin
                if (lfsr[0])
                    lfsr = (lfsr >> 1) ^ LFSR_TAPS;
                else
                    lfsr = lfsr >> 1;
                tags[lfsr[WAY_W-1:0]][set_idx] = tag;
            end
            t.delay = (t.uncacheable || !t.hit) ? miss_delay : hit_delay;
            pending_timings.push_back(t);
        endfunction

        function void check_timing(logic [DELAY_W-1:0] d, logic h, logic u);
            fetch_timing_t want;
            if (pending_timings.size() == 0)
            begin
                $display("%0t: unexpected result word: delay %0d hit %b uncacheable %b",
                         $time, d, h, u);
                mismatches++;
                return;
            end
            want = pending_timings.pop_front();
            if (d !== want.delay)
            begin
                $display("%0t: delay expected %0d, actual %0d", $time, want.delay, d);
                mismatches++;
            end
            if (h !== want.hit)
            begin
                $display("%0t: hit expected %b, actual %b", $time, want.hit, h);
                mismatches++;
            end
            if (u !== want.uncacheable)
            begin
                $display("%0t: uncacheable expected %b, actual %b",
                         $time, want.uncacheable, u);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_timings.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [ADDR_W-1:0]      fetch_address;
    logic                   out_valid;
    logic                   out_stall;
    logic [DELAY_W-1:0]     delay;
    logic                   hit;
    logic                   uncacheable;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [DELAY_W-1:0]     cfg_data;

    fetch_timing_predictor model;
    int                    in_idle_max;
    int                    out_idle_max;
    int                    watchdog_count;
    tag_t                  tag_pool [POOL_SIZE];
    int                    idle_choices [3] = '{0, 3, IDLE_MAX};

    // Directed fetch words, checked against the reset delays of 1 and 10.
    logic [ADDR_W-1:0] directed_addrs [] = '{
        // Tag zero hits a cleared entry right after reset, yet it is uncacheable.
        32'h0000_0000, 32'h0000_0FFF,
        // Edges of the cacheable window: first a miss and fill, then a hit.
        32'h8000_0000, 32'h8000_0000, 32'hBFFF_FFFF, 32'hBFFF_FFFF,
        // Uncacheable addresses still allocate, so a repeat hits with the memory delay.
        32'hC000_0000, 32'hC000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        // Six tags in one set push out the cleared entries and force evictions.
        32'h8000_1100, 32'h8000_2104, 32'h8000_3108, 32'h8000_410C,
        32'h8000_5100, 32'h8000_6100, 32'h8000_1100, 32'h8000_2100,
        // Tag zero in that set may have been evicted by now.
        32'h0000_0100
    };

    icache_hit_timing_model uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .fetch_address (fetch_address),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .delay         (delay),
        .hit           (hit),
        .uncacheable   (uncacheable),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    // The watchdog counts cycles in which no channel moves a word. A hung block
    // trips it long before the run would otherwise end.
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
            (cfg_valid && cfg_ready === 1'b1))
            watchdog_count = 0;
        else
            watchdog_count = watchdog_count + 1;
        if (watchdog_count >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side. Before each word the receiver holds stall for a random number of
    // cycles, so the stall lands on every phase of the lookup. All drives
    // happen at the falling edge; the word is taken at the rising edge where
    // out_valid is high and stall is low.
    initial
    begin : result_receiver
        int stall_cycles;
        forever
        begin
            stall_cycles = $urandom_range(0, out_idle_max);
            @(negedge clk);
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            model.check_timing(delay, hit, uncacheable);
        end
    end

    // Sends one fetch word after a random gap. Valid stays high from one word to the
    // next when the gap is zero, so back-to-back words are offered at full rate.
    task automatic send_fetch(input logic [ADDR_W-1:0] addr);
        int gap;
        gap = $urandom_range(0, in_idle_max);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        fetch_address <= addr;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        model.note_fetch(addr);
    endtask

    // Writes one register; cfg_valid is left high so a following write runs back to back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [DELAY_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge clk);
        while (cfg_ready !== 1'b1)
            @(posedge clk);
        model.write_reg(index, data);
    endtask

    // Programs both delays and pokes an index that does not exist, which must be ignored.
    task automatic program_delays(input logic [DELAY_W-1:0] cache_cycles,
                                  input logic [DELAY_W-1:0] memory_cycles);
        write_reg(REG_HIT_DELAY, cache_cycles);
        write_reg(REG_MISS_DELAY, memory_cycles);
        write_reg(CFG_INDEX_W'($urandom_range(REG_MISS_DELAY + 1, 2 ** CFG_INDEX_W - 1)),
                  DELAY_W'($urandom));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // The sender stops and waits until every expected result word has been checked,
    // then lets the pipeline settle before anything is reprogrammed.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A small pool of tags per phase keeps the working set inside a few sets, so hits,
    // misses and evictions all happen often. Most tags are cacheable; tag zero and
    // fully random tags are mixed in.
    task automatic refill_pool();
        int pick;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pick = $urandom_range(0, 9);
            tag_pool[i] = TAG_W'($urandom);
            if (pick < 7)
                tag_pool[i][TAG_W-1 -: 2] = 2'b10;
            else if (pick == 7)
                tag_pool[i] = '0;
        end
    endtask

    // Sixty percent of random words hit the working set, fifteen percent sit near the
    // window edges and the rest are fully random addresses.
    function automatic logic [ADDR_W-1:0] random_address();
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base;
        int                pick;
        pick = $urandom_range(0, 99);
        addr = $urandom;
        if (pick < 60)
        begin
            addr[ADDR_W-1 -: TAG_W] = tag_pool[$urandom_range(0, POOL_SIZE - 1)];
            addr[SET_LSB +: SET_W] = SET_W'($urandom_range(0, 7));
        end
        else if (pick < 75)
        begin
            base = $urandom_range(0, 1) ? CACHE_HIGH : CACHE_LOW;
            addr = base - 32'h2000 + $urandom_range(0, 32'h3FFF);
        end
        return addr;
    endfunction

    initial
    begin : stimulus
        logic [DELAY_W-1:0] cache_cycles;
        logic [DELAY_W-1:0] memory_cycles;
        in_valid = 1'b0;
        fetch_address = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        watchdog_count = 0;
        in_idle_max = 3;
        out_idle_max = 3;
        model = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed words run with the reset delays before any register is touched.
        foreach (directed_addrs[i])
            send_fetch(directed_addrs[i]);
        drain();

        // Each phase reprograms the delays, picks new idling for both sides and sends
        // random words. The first phases cover the extremes of both registers.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            cache_cycles = DELAY_W'($urandom);
            memory_cycles = DELAY_W'($urandom);
            if (phase == 0)
            begin
                cache_cycles = '0;
                memory_cycles = DELAY_MAX;
            end
            else if (phase == 1)
            begin
                cache_cycles = DELAY_MAX;
                memory_cycles = '0;
            end
            else if (phase == 2)
            begin
                cache_cycles = '0;
                memory_cycles = '0;
            end
            else if (phase == 3)
            begin
                cache_cycles = DELAY_MAX;
                memory_cycles = DELAY_MAX;
            end
            program_delays(cache_cycles, memory_cycles);
            in_idle_max = idle_choices[phase % 3];
            out_idle_max = idle_choices[(phase / 2) % 3];
            refill_pool();
            repeat (WORDS_PER_PHASE) send_fetch(random_address());
            drain();
        end

        if (model.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ichtm_pkg.sv
rtl/ichtm_tag_ram.sv
rtl/ichtm_replace.sv
rtl/icache_hit_timing_model.sv
tb/tb_top.sv
